FILE: src/lzss_pkg.sv
// Shared constants for the LZSS stream decompressor.
package lzss_pkg;

  // Token parser phase codes
  localparam logic [1:0] PH_FLAG  = 2'd0;
  localparam logic [1:0] PH_LIT   = 2'd1;
  localparam logic [1:0] PH_MATCH = 2'd2;

  localparam int unsigned LIT_BITS   = 8;
  localparam logic [7:0]  SPACE_BYTE = 8'h20;
  localparam logic [7:0]  ZERO_BYTE  = 8'h00;

endpackage

FILE: src/lzss_stream_decompressor.sv
// Top level: LZSS stream decompressor with history window in a RAM.
// Data path: a literal goes through the data stage into the output register; a match
//   reads the window RAM into the data stage, then the output register.
// Input stalls while a match copy or a pending byte is in flight; the single RAM read
//   port sets the one-byte-per-cycle copy rate, held off while the output stalls.
// Reset/restart: no clearing pass; a fill count marks written window entries, so the
//   block is ready in the first cycle after reset or after a restart beat.
module lzss_stream_decompressor #(
  parameter int unsigned WINDOW_BITS = 11,
  parameter int unsigned LENGTH_BITS = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // compressed input
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] packed_byte_i,
  input  logic       restart_i,
  // decompressed output
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] plain_byte_o,
  output logic       last_of_run_o
);

  localparam int unsigned WIN_SIZE   = 1 << WINDOW_BITS;
  localparam int unsigned LOOKAHEAD  = (1 << LENGTH_BITS) + 1;
  localparam int unsigned MATCH_BITS = WINDOW_BITS + LENGTH_BITS;
  localparam int unsigned CNT_W      = $clog2(MATCH_BITS + 1);
  localparam int unsigned LEN_W      = LENGTH_BITS + 1;
  localparam logic [WINDOW_BITS-1:0] INIT_WP = WINDOW_BITS'(WIN_SIZE - LOOKAHEAD);

  // ---------------------------------------------------------------------------
  // Bit parser state: phase, collected token bits and bit count.
  // ---------------------------------------------------------------------------
  logic [1:0]            phase_q, phase_d;
  logic [MATCH_BITS-1:0] tok_q, tok_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  // Window bookkeeping: write pointer and count of entries written since restart.
  logic [WINDOW_BITS-1:0] wp_q;
  logic [WINDOW_BITS:0]   fill_q;

  // Copy engine: next read address and bytes still to be read.
  logic [WINDOW_BITS-1:0] pos_q;
  logic [LEN_W-1:0]       remain_q;

  // Data stage: one byte waiting to be emitted, either direct or from RAM.
  logic       rd_pend_q;
  logic       direct_q;   // byte_q holds the value (literal or forwarded)
  logic       valid_q;    // RAM entry was written since restart
  logic [7:0] byte_q;
  logic [7:0] dflt_q;     // reset content of the read entry
  logic       last_q;

  // Output register
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  logic [7:0] rdata;
  logic [7:0] cur_byte;
  logic       out_free, fire, issue, in_fire, busy;
  logic       tok_done, tok_lit;
  logic [MATCH_BITS-1:0] tok_done_val;
  logic [WINDOW_BITS-1:0] rd_off;
  logic       rd_valid, rd_fwd;
  logic [7:0] rd_dflt;

  assign busy       = (remain_q != '0) || rd_pend_q;
  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;

  // ---------------------------------------------------------------------------
  // Parse the eight bits of a beat, MSB first. A beat finishes at most one token;
  // bits after it start the next token and stay pending.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [1:0]            ph;
    logic [MATCH_BITS-1:0] tb;
    logic [CNT_W-1:0]      cn;
    ph           = restart_i ? lzss_pkg::PH_FLAG : phase_q;
    tb           = restart_i ? '0 : tok_q;
    cn           = restart_i ? '0 : cnt_q;
    tok_done     = 1'b0;
    tok_lit      = 1'b0;
    tok_done_val = '0;
    for (int i = 7; i >= 0; i--) begin
      if (ph == lzss_pkg::PH_LIT || ph == lzss_pkg::PH_MATCH) begin
        tb = {tb[MATCH_BITS-2:0], packed_byte_i[i]};
        cn = cn + 1'b1;
        if (ph == lzss_pkg::PH_LIT && cn == CNT_W'(lzss_pkg::LIT_BITS)) begin
          tok_done     = 1'b1;
          tok_lit      = 1'b1;
          tok_done_val = tb;
          ph           = lzss_pkg::PH_FLAG;
        end else if (ph == lzss_pkg::PH_MATCH && cn == CNT_W'(MATCH_BITS)) begin
          tok_done     = 1'b1;
          tok_done_val = tb;
          ph           = lzss_pkg::PH_FLAG;
        end
      end else begin
        tb = '0;
        cn = '0;
        ph = packed_byte_i[i] ? lzss_pkg::PH_LIT : lzss_pkg::PH_MATCH;
      end
    end
    phase_d = ph;
    tok_d   = tb;
    cnt_d   = cn;
  end

  // ---------------------------------------------------------------------------
  // Emit path. The data stage fires into the output register and writes the
  // window at the write pointer in the same cycle.
  // ---------------------------------------------------------------------------
  assign out_free = !out_valid_q || !out_stall_i;
  assign fire     = rd_pend_q && out_free;
  assign issue    = (remain_q != '0) && (!rd_pend_q || fire);
  assign cur_byte = direct_q ? byte_q : (valid_q ? rdata : dflt_q);

  // Entry status at read time. An entry counts as written when its distance from
  // the restart pointer is below the fill count. A read of the entry being written
  // this very cycle (source at the write pointer) takes the byte by forwarding.
  assign rd_off   = pos_q - INIT_WP;
  assign rd_valid = fill_q[WINDOW_BITS] || ({1'b0, rd_off} < fill_q);
  assign rd_fwd   = fire && (pos_q == wp_q);
  assign rd_dflt  = (pos_q < INIT_WP) ? lzss_pkg::SPACE_BYTE : lzss_pkg::ZERO_BYTE;

  lzss_ram #(
    .WIDTH (8),
    .DEPTH (WIN_SIZE)
  ) u_window (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (wp_q),
    .wdata_i (cur_byte),
    .re_i    (issue),
    .raddr_i (pos_q),
    .rdata_o (rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= lzss_pkg::PH_FLAG;
      cnt_q       <= '0;
      wp_q        <= INIT_WP;
      fill_q      <= '0;
      remain_q    <= '0;
      rd_pend_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
      end

      if (in_fire && restart_i) begin
        wp_q   <= INIT_WP;
        fill_q <= '0;
      end else if (fire) begin
        wp_q <= wp_q + 1'b1;
        if (!fill_q[WINDOW_BITS]) begin
          fill_q <= fill_q + 1'b1;
        end
      end

      // in_fire only happens with the engine idle, so it never meets fire/issue
      if (in_fire && tok_done && !tok_lit) begin
        remain_q <= LEN_W'(tok_done_val[LENGTH_BITS-1:0]) + LEN_W'(2);
      end else if (issue) begin
        remain_q <= remain_q - 1'b1;
      end

      if (in_fire && tok_done && tok_lit) begin
        rd_pend_q <= 1'b1;
      end else if (issue) begin
        rd_pend_q <= 1'b1;
      end else if (fire) begin
        rd_pend_q <= 1'b0;
      end

      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tok_q <= tok_d;
      pos_q <= tok_done_val[MATCH_BITS-1:LENGTH_BITS];
      if (tok_lit) begin
        direct_q <= 1'b1;
        byte_q   <= tok_done_val[7:0];
        last_q   <= 1'b1;
      end
    end else if (issue) begin
      pos_q    <= pos_q + 1'b1;
      direct_q <= rd_fwd;
      byte_q   <= cur_byte;
      valid_q  <= rd_valid;
      dflt_q   <= rd_dflt;
      last_q   <= (remain_q == LEN_W'(1));
    end
    if (fire) begin
      out_byte_q <= cur_byte;
      out_last_q <= last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign plain_byte_o  = out_byte_q;
  assign last_of_run_o = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= (WINDOW_BITS+1)'(WIN_SIZE))
    else $error("window fill count overran the window size");

  a_match_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && tok_done |=> in_stall_o)
    else $error("input not held off after a finished token");

  a_wp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> wp_q == $past(wp_q + 1'b1))
    else $error("write pointer did not advance with an emitted byte");

endmodule

FILE: src/lzss_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzss_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: bench/tb_lzss_stream_decompressor.sv
// Self-checking testbench for the LZSS stream decompressor: directed tokens, then random streams.
module tb_lzss_stream_decompressor;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WIN_BITS  = 11;
  localparam int unsigned LEN_BITS  = 4;
  localparam int unsigned WIN_SIZE  = 1 << WIN_BITS;
  localparam int unsigned LOOKAHEAD = (1 << LEN_BITS) + 1;
  localparam int unsigned TOK_BITS  = WIN_BITS + LEN_BITS;
  localparam int unsigned LEN_MAX   = (1 << LEN_BITS) - 1;
  // a match of 17 bytes plus the read startup, with slack
  localparam int unsigned TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } plain_t;

  // DUT ports; the inputs are known from time zero
  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic       in_stall_o;
  logic [7:0] packed_byte_i = 8'h00;
  logic       restart_i     = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i   = 1'b0;
  logic [7:0] plain_byte_o;
  logic       last_of_run_o;

  lzss_stream_decompressor #(
    .WINDOW_BITS(WIN_BITS),
    .LENGTH_BITS(LEN_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .packed_byte_i(packed_byte_i),
    .restart_i    (restart_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .plain_byte_o (plain_byte_o),
    .last_of_run_o(last_of_run_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: far beyond the slowest legal run (every beat a 17-byte match,
  // receiver stalling 87% of cycles, sender gaps on top).
  initial begin
    #5_000_000;
    $display("tb_lzss_stream_decompressor NOT OK");
    $finish;
  end

  // ------------------------------------------------------------------
  // Decoder model: own copy of window, write pointer and bit reader
  // ------------------------------------------------------------------
  logic [7:0]          hist_model [WIN_SIZE];
  logic [WIN_BITS-1:0] wp_model;
  logic [TOK_BITS-1:0] tok_bits;
  int unsigned         tok_cnt;
  logic [1:0]          tok_phase;

  plain_t expected_q[$];   // decoded bytes still owed by the DUT
  int     err_count;
  int     beats_sent;

  int send_idle_pct;       // chance per cycle that the sender holds off
  int stall_pct;           // chance per cycle that the receiver stalls

  function automatic void clear_window();
    for (int i = 0; i < WIN_SIZE; i++) begin
      hist_model[i] = (i < WIN_SIZE - LOOKAHEAD) ? lzss_pkg::SPACE_BYTE : lzss_pkg::ZERO_BYTE;
    end
    wp_model  = WIN_BITS'(WIN_SIZE - LOOKAHEAD);
    tok_bits  = '0;
    tok_cnt   = 0;
    tok_phase = lzss_pkg::PH_FLAG;
  endfunction

  // every decoded byte goes to the output and back into the window
  function automatic void store_plain(input logic [7:0] v);
    hist_model[wp_model] = v;
    wp_model = wp_model + 1'b1;
    expected_q.push_back('{data: v, last: 1'b0});
  endfunction

  // Decode one accepted beat, MSB first; queue the bytes it produces.
  function automatic void decode_beat(input logic [7:0] b, input logic r);
    int unsigned         n_out;
    logic                bitv;
    logic [WIN_BITS-1:0] rd;
    int unsigned         len;
    n_out = 0;
    if (r) clear_window();
    for (int i = 7; i >= 0; i--) begin
      bitv = b[i];
      if (tok_phase == lzss_pkg::PH_LIT || tok_phase == lzss_pkg::PH_MATCH) begin
        tok_bits = {tok_bits[TOK_BITS-2:0], bitv};
        tok_cnt++;
        if (tok_phase == lzss_pkg::PH_LIT && tok_cnt == lzss_pkg::LIT_BITS) begin
          store_plain(tok_bits[7:0]);
          n_out++;
          tok_phase = lzss_pkg::PH_FLAG;
        end else if (tok_phase == lzss_pkg::PH_MATCH && tok_cnt == TOK_BITS) begin
          rd  = tok_bits[TOK_BITS-1:LEN_BITS];
          len = tok_bits[LEN_BITS-1:0] + 2;
          // strictly byte by byte, so overlapping copies see fresh bytes
          for (int k = 0; k < len; k++) begin
            store_plain(hist_model[rd]);
            rd = rd + 1'b1;
          end
          n_out += len;
          tok_phase = lzss_pkg::PH_FLAG;
        end
      end else begin
        // flag bit; a stray phase code also lands here
        tok_bits  = '0;
        tok_cnt   = 0;
        tok_phase = bitv ? lzss_pkg::PH_LIT : lzss_pkg::PH_MATCH;
      end
    end
    if (n_out > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endfunction

  // ------------------------------------------------------------------
  // Output side: random stall, and compare each accepted beat
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    err_count++;
  endtask

  always @(posedge clk_i) begin : out_check
    plain_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("output beat with nothing owed", plain_byte_o, 0);
      end else begin
        want = expected_q.pop_front();
        if (plain_byte_o !== want.data) report_mismatch("plain_byte", plain_byte_o, want.data);
        if (last_of_run_o !== want.last) report_mismatch("last_of_run", last_of_run_o, want.last);
      end
    end
  end

  // ------------------------------------------------------------------
  // Input side
  // ------------------------------------------------------------------
  task automatic set_idling(input int snd, input int stl);
    send_idle_pct = snd;
    stall_pct     = stl;
  endtask

  // One input beat. Valid stays high between back-to-back beats; it only
  // drops when a random gap is taken, and then time advances before it rises.
  task automatic send_beat(input logic [7:0] b, input logic r);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    packed_byte_i <= b;
    restart_i     <= r;
    do @(posedge clk_i); while (in_stall_o);
    decode_beat(b, r);
    beats_sent++;
  endtask

  // Hold the sender until every owed byte has come out.
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_q.size() != 0);
  endtask

  // ------------------------------------------------------------------
  // Token stream builder: tokens become bits, bits become beats
  // ------------------------------------------------------------------
  bit                  bit_fifo[$];
  logic                next_restart;
  logic [WIN_BITS-1:0] gen_wp;   // write pointer as the encoder sees it

  task automatic push_bits(input int unsigned v, input int n);
    logic [7:0] b;
    for (int i = n - 1; i >= 0; i--) bit_fifo.push_back(v[i]);
    while (bit_fifo.size() >= 8) begin
      for (int i = 0; i < 8; i++) b = {b[6:0], bit_fifo.pop_front()};
      send_beat(b, next_restart);
      next_restart = 1'b0;
    end
  endtask

  task automatic start_stream();
    bit_fifo.delete();
    next_restart = 1'b1;
    gen_wp       = WIN_BITS'(WIN_SIZE - LOOKAHEAD);
  endtask

  // Pad to a beat boundary; the pad is at most 7 bits, so it can at most leave a
  // partial token behind, which the next restart throws away.
  task automatic finish_stream();
    while (bit_fifo.size() % 8 != 0) bit_fifo.push_back(1'($urandom_range(1)));
    push_bits(0, 0);
  endtask

  task automatic put_literal(input logic [7:0] v);
    push_bits(1, 1);
    push_bits(v, 8);
    gen_wp = gen_wp + 1'b1;
  endtask

  task automatic put_match(input logic [WIN_BITS-1:0] pos, input int unsigned code);
    push_bits(0, 1);
    push_bits(pos, WIN_BITS);
    push_bits(code, LEN_BITS);
    gen_wp = gen_wp + WIN_BITS'(code + 2);
  endtask

  task automatic put_random_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) begin
      put_literal(8'($urandom_range(255)));
    end else if (pick < 70) begin
      // recent history, often overlapping the bytes being written
      put_match(gen_wp - WIN_BITS'($urandom_range(20, 1)), $urandom_range(LEN_MAX));
    end else if (pick < 85) begin
      put_match(WIN_BITS'($urandom_range(WIN_SIZE - 1)), $urandom_range(LEN_MAX));
    end else if (pick < 92) begin
      put_match(gen_wp, $urandom_range(LEN_MAX));
    end else begin
      put_match($urandom_range(1) ? WIN_BITS'(WIN_SIZE - 1) : '0,
                $urandom_range(1) ? LEN_MAX : 0);
    end
  endtask

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // literals at both ends of the byte range, straight after restart
  task automatic test_literals();
    set_idling(0, 0);
    start_stream();
    put_literal(8'h00);
    put_literal(8'hFF);
    put_literal(8'h81);
    put_literal(8'h7E);
  endtask

  // continues the stream above: shortest and longest matches, window wrap,
  // the zero tail of the reset window, overlap and self-reference
  task automatic test_matches();
    put_match('0, 0);
    put_match(WIN_BITS'(WIN_SIZE - 1), LEN_MAX);
    put_match(gen_wp - WIN_BITS'(4), LEN_MAX);
    put_match(gen_wp - WIN_BITS'(1), 5);
    put_match(gen_wp, 0);
    finish_stream();
    drain();
  endtask

  // restart mid-token drops the partial token; beats with no finished token
  task automatic test_restart_partial();
    send_beat(8'h00, 1'b1);   // partial match only, no output
    send_beat(8'hFF, 1'b0);   // completes the match
    send_beat(8'hFF, 1'b1);   // partial literal left pending
    send_beat(8'h00, 1'b1);   // literal dropped, new partial match
    send_beat(8'hC3, 1'b1);
    send_beat(8'h5A, 1'b0);
    drain();
  endtask

  // well-formed token streams with random content, occasional restarts
  task automatic test_random_stream(input int snd, input int stl, input int n_beats);
    int stop_at;
    set_idling(snd, stl);
    stop_at = beats_sent + n_beats;
    start_stream();
    while (beats_sent < stop_at) begin
      if ($urandom_range(49) == 0) begin
        finish_stream();
        start_stream();
      end
      put_random_token();
    end
    finish_stream();
    drain();
  endtask

  // raw random beats, restart now and then
  task automatic test_noise(input int n_beats);
    set_idling(35, 35);
    repeat (n_beats) send_beat(8'($urandom_range(255)), $urandom_range(15) == 0);
    drain();
  endtask

  initial begin : main_seq
    err_count  = 0;
    beats_sent = 0;
    set_idling(0, 0);
    clear_window();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_literals();
    test_matches();
    test_restart_partial();
    test_random_stream(0, 0, 45);
    test_random_stream(87, 0, 45);
    test_random_stream(0, 87, 45);
    test_random_stream(35, 35, 45);
    test_noise(20);

    // quiet tail: catch any stray output beats
    set_idling(0, 0);
    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_lzss_stream_decompressor OK");
    end else begin
      $display("tb_lzss_stream_decompressor NOT OK");
    end
    $finish;
  end

endmodule
